FILE: rtl/core/aabb_pkg.sv
`timescale 1ns / 1ps

package aabb_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int CFG_NUM       = 6;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int COORD_W       = 32;
	localparam int HALF_W        = 31;
	localparam int PROD_W        = 2 * COORD_W;
	localparam int MAG_W         = COORD_W + HALF_W;
	localparam int CSUM_W        = PROD_W + 2;
	localparam int ESUM_W        = MAG_W + 2;
	localparam int ACC_W         = CSUM_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_X_XY = 3'd0,
		CFG_ROW_X_ZT = 3'd1,
		CFG_ROW_Y_XY = 3'd2,
		CFG_ROW_Y_ZT = 3'd3,
		CFG_ROW_Z_XY = 3'd4,
		CFG_ROW_Z_ZT = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic [HALF_W-1:0]         half_x;
		logic [HALF_W-1:0]         half_y;
		logic [HALF_W-1:0]         half_z;
	} box_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] low_x;
		logic signed [COORD_W-1:0] low_y;
		logic signed [COORD_W-1:0] low_z;
		logic signed [COORD_W-1:0] high_x;
		logic signed [COORD_W-1:0] high_y;
		logic signed [COORD_W-1:0] high_z;
	} box_res_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic [ACC_W-1:0] v);
		logic [COORD_W-1:0] r;
		if ((&v[ACC_W-1:COORD_W-1]) || !(|v[ACC_W-1:COORD_W-1])) begin
			r = v[COORD_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/aabb_affine_transform_core.sv
`timescale 1ns / 1ps

// A taken request runs through the valid registers val_s1, val_s2, val_s3 and val_s4; done is driven by val_s4.
// Throughput: one request per cycle once busy is low; the four stages are multiply, sum, bound with offset,
// and saturate into the output register.
// Reset: the transform returns to identity, the pipeline empties and busy is high until the
// first clock edge after reset is released. Results are shown for one cycle only.
module aabb_affine_transform_core
	import aabb_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  box_req_t              req,
	output logic                  done,
	output box_res_t              result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CFG_DATA_W-1:0] row_xy_q [3];
	logic [CFG_DATA_W-1:0] row_zt_q [3];
	logic                  busy_q;
	logic                  accept;

	logic signed [COORD_W-1:0] center [3];
	logic [HALF_W-1:0]         half   [3];
	logic signed [COORD_W-1:0] coef   [3][3];

	logic val_s1, val_s2, val_s3, val_s4;

	logic signed [PROD_W-1:0] cprod_s1 [3][3];
	logic [MAG_W-1:0]         eprod_s1 [3][3];
	logic signed [CSUM_W-1:0] csum_s2  [3];
	logic [ESUM_W-1:0]        esum_s2  [3];
	logic signed [ACC_W-1:0]  low_s3   [3];
	logic signed [ACC_W-1:0]  high_s3  [3];
	box_res_t                 result_s4;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = val_s4;
	assign result = result_s4;

	assign center[0] = req.center_x;
	assign center[1] = req.center_y;
	assign center[2] = req.center_z;
	assign half[0]   = req.half_x;
	assign half[1]   = req.half_y;
	assign half[2]   = req.half_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_xy_q[0] <= CFG_DATA_W'(1) << (COORD_W + FRAC_BITS);
			row_zt_q[0] <= '0;
			row_xy_q[1] <= CFG_DATA_W'(1) << FRAC_BITS;
			row_zt_q[1] <= '0;
			row_xy_q[2] <= '0;
			row_zt_q[2] <= CFG_DATA_W'(1) << (COORD_W + FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ROW_X_XY: row_xy_q[0] <= cfg_data;
				CFG_ROW_X_ZT: row_zt_q[0] <= cfg_data;
				CFG_ROW_Y_XY: row_xy_q[1] <= cfg_data;
				CFG_ROW_Y_ZT: row_zt_q[1] <= cfg_data;
				CFG_ROW_Z_XY: row_xy_q[2] <= cfg_data;
				CFG_ROW_Z_ZT: row_zt_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			val_s1 <= accept;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
		end
	end

	// The extreme corners of each output axis follow from the coefficient signs, so the low
	// bound is the centre image minus the summed magnitudes and the high bound the centre
	// image plus them. Flooring and saturation are monotone and keep that order.
	for (genvar r = 0; r < 3; r++) begin : g_row
		logic [COORD_W-1:0] mag [3];

		assign coef[r][0] = $signed(row_xy_q[r][2*COORD_W-1:COORD_W]);
		assign coef[r][1] = $signed(row_xy_q[r][COORD_W-1:0]);
		assign coef[r][2] = $signed(row_zt_q[r][2*COORD_W-1:COORD_W]);

		for (genvar i = 0; i < 3; i++) begin : g_term
			assign mag[i] = coef[r][i][COORD_W-1] ? (~coef[r][i] + COORD_W'(1)) : coef[r][i];

			always_ff @(posedge clk) begin
				cprod_s1[r][i] <= coef[r][i] * center[i];
				eprod_s1[r][i] <= mag[i] * half[i];
			end
		end

		always_ff @(posedge clk) begin
			csum_s2[r] <= CSUM_W'(cprod_s1[r][0]) + CSUM_W'(cprod_s1[r][1])
				+ CSUM_W'(cprod_s1[r][2]);
			esum_s2[r] <= ESUM_W'(eprod_s1[r][0]) + ESUM_W'(eprod_s1[r][1])
				+ ESUM_W'(eprod_s1[r][2]);
			low_s3[r]  <= ((ACC_W'(csum_s2[r]) - $signed(ACC_W'(esum_s2[r]))) >>> FRAC_BITS)
				+ ACC_W'($signed(row_zt_q[r][COORD_W-1:0]));
			high_s3[r] <= ((ACC_W'(csum_s2[r]) + $signed(ACC_W'(esum_s2[r]))) >>> FRAC_BITS)
				+ ACC_W'($signed(row_zt_q[r][COORD_W-1:0]));
		end
	end

	always_ff @(posedge clk) begin
		result_s4.low_x  <= sat_coord(low_s3[0]);
		result_s4.low_y  <= sat_coord(low_s3[1]);
		result_s4.low_z  <= sat_coord(low_s3[2]);
		result_s4.high_x <= sat_coord(high_s3[0]);
		result_s4.high_y <= sat_coord(high_s3[1]);
		result_s4.high_z <= sat_coord(high_s3[2]);
	end

`ifndef SYNTHESIS
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("Result strobe without a request four cycles earlier.");

	a_request_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("Request did not produce a result after four cycles.");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.low_x <= result.high_x) && (result.low_y <= result.high_y)
			&& (result.low_z <= result.high_z))
		else $error("Low bound exceeds high bound.");

	a_point_box_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(req.half_x == '0 && req.half_y == '0 && req.half_z == '0, 4))
		|-> (result.low_x == result.high_x) && (result.low_y == result.high_y)
			&& (result.low_z == result.high_z))
		else $error("A box with no extent gave bounds that differ.");
`endif

endmodule

FILE: tb/sv/aabb_affine_transform_core_tb.sv
`timescale 1ns / 1ps

module aabb_affine_transform_core_tb;
	import aabb_pkg::*;

	localparam int FRAC        = DEF_FRAC_BITS;
	localparam int WIDE_W      = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

	localparam logic [COORD_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] Q_MIN  = 32'h8000_0000;
	localparam logic [COORD_W-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [COORD_W-1:0] Q_HALF = 32'h0000_8000;
	localparam logic [COORD_W-1:0] Q_NEG_HALF = 32'hFFFF_8000;
	localparam logic [HALF_W-1:0]  H_MAX  = 31'h7FFF_FFFF;

	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t COORD_MAX = wide_t'($signed(Q_MAX));
	localparam wide_t COORD_MIN = wide_t'($signed(Q_MIN));

	typedef enum {
		XF_RANDOM,
		XF_HALF_SCALE,
		XF_MOST_NEG,
		XF_MOST_POS,
		XF_ZERO,
		XF_SMALL
	} xform_style_t;

	typedef struct {
		box_req_t box;
		bit       drain_first;
	} queued_box_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	box_req_t              req = '0;
	logic                  done;
	box_res_t              result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	queued_box_t           pending_boxes[$];
	box_res_t              expected_bounds[$];
	logic [CFG_DATA_W-1:0] xform_regs[CFG_NUM];
	int                    send_idle_pct = 0;
	int                    accepted_count = 0;
	int                    received_count = 0;
	int                    error_count = 0;
	int                    cycle_count = 0;

	aabb_affine_transform_core #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [COORD_W-1:0] map_axis(input logic [CFG_DATA_W-1:0] xy,
			input logic [CFG_DATA_W-1:0] zt, input wide_t px, input wide_t py, input wide_t pz);
		wide_t acc;
		acc = wide_t'($signed(xy[63:32])) * px + wide_t'($signed(xy[31:0])) * py
			+ wide_t'($signed(zt[63:32])) * pz;
		acc = (acc >>> FRAC) + wide_t'($signed(zt[31:0]));
		if (acc > COORD_MAX) begin
			acc = COORD_MAX;
		end else if (acc < COORD_MIN) begin
			acc = COORD_MIN;
		end
		return acc[COORD_W-1:0];
	endfunction

	function automatic box_res_t predict_bounds(input box_req_t b);
		wide_t                     ctr[3];
		wide_t                     ext[3];
		wide_t                     crn[3];
		logic signed [COORD_W-1:0] v;
		logic signed [COORD_W-1:0] lo[3];
		logic signed [COORD_W-1:0] hi[3];
		box_res_t                  r;
		ctr[0] = wide_t'($signed(b.center_x));
		ctr[1] = wide_t'($signed(b.center_y));
		ctr[2] = wide_t'($signed(b.center_z));
		ext[0] = wide_t'({1'b0, b.half_x});
		ext[1] = wide_t'({1'b0, b.half_y});
		ext[2] = wide_t'({1'b0, b.half_z});
		for (int k = 0; k < 8; k++) begin
			for (int a = 0; a < 3; a++) begin
				crn[a] = k[a] ? ctr[a] + ext[a] : ctr[a] - ext[a];
			end
			for (int a = 0; a < 3; a++) begin
				v = map_axis(xform_regs[2 * a], xform_regs[2 * a + 1], crn[0], crn[1], crn[2]);
				if (k == 0 || v < lo[a]) begin
					lo[a] = v;
				end
				if (k == 0 || v > hi[a]) begin
					hi[a] = v;
				end
			end
		end
		r.low_x  = lo[0];
		r.low_y  = lo[1];
		r.low_z  = lo[2];
		r.high_x = hi[0];
		r.high_y = hi[1];
		r.high_z = hi[2];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : request_driver
		queued_box_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				expected_bounds.push_back(predict_bounds(req));
				accepted_count <= accepted_count + 1;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& !(pending_boxes[0].drain_first
					&& accepted_count + (start ? 1 : 0) != received_count)) begin
				nxt = pending_boxes.pop_front();
				start <= 1'b1;
				req   <= nxt.box;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(input string label, input logic [COORD_W-1:0] got,
			input logic [COORD_W-1:0] want);
		if (got !== want) begin
			error_count++;
			if (error_count <= REPORT_MAX) begin
				$display("%s mismatch on result %0d: expected %0d, got %0d", label,
					received_count, $signed(want), $signed(got));
			end
		end
	endtask

	always @(posedge clk) begin : result_monitor
		box_res_t want;
		if (arst_n && done) begin
			if (expected_bounds.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX) begin
					$display("result with no request outstanding: %h", result);
				end
			end else begin
				want = expected_bounds.pop_front();
				check_field("low_x", result.low_x, want.low_x);
				check_field("low_y", result.low_y, want.low_y);
				check_field("low_z", result.low_z, want.low_z);
				check_field("high_x", result.high_x, want.high_x);
				check_field("high_y", result.high_y, want.high_y);
				check_field("high_z", result.high_z, want.high_z);
			end
			received_count <= received_count + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		if (idx < CFG_NUM) begin
			xform_regs[idx] = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] rand_coef();
		case ($urandom_range(5))
			0: return $urandom;
			1: return Q_MIN;
			2: return Q_MAX;
			3: return '0;
			default: return COORD_W'(int'($urandom_range(2 ** 19)) - 2 ** 18);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] small_q();
		return COORD_W'(int'($urandom_range(2 ** 19)) - 2 ** 18);
	endfunction

	task automatic load_transform(input xform_style_t style);
		logic [CFG_DATA_W-1:0] val;
		for (int r = 0; r < CFG_NUM; r++) begin
			case (style)
				XF_HALF_SCALE: begin
					case (cfg_idx_t'(r))
						CFG_ROW_X_XY: val = {Q_HALF, 32'h0};
						CFG_ROW_Y_XY: val = {32'h0, Q_NEG_HALF};
						CFG_ROW_Z_XY: val = {Q_HALF, Q_NEG_HALF};
						CFG_ROW_Z_ZT: val = {Q_HALF, small_q()};
						default: val = {32'h0, small_q()};
					endcase
				end
				XF_MOST_NEG: val = {Q_MIN, Q_MIN};
				XF_MOST_POS: val = {Q_MAX, Q_MAX};
				XF_ZERO: val = r[0] ? {32'h0, 32'($urandom)} : '0;
				XF_SMALL: val = {small_q(), small_q()};
				default: val = {rand_coef(), rand_coef()};
			endcase
			write_reg(cfg_idx_t'(r), val);
		end
		write_reg(CFG_IDX_SPARE_LO, {32'($urandom), 32'($urandom)});
		write_reg(CFG_IDX_SPARE_HI, {Q_ONE, Q_ONE});
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_boxes.size() != 0 || start || accepted_count != received_count);
		repeat (6) @(negedge clk);
	endtask

	function automatic box_req_t make_box(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input logic [COORD_W-1:0] cz, input logic [HALF_W-1:0] hx,
			input logic [HALF_W-1:0] hy, input logic [HALF_W-1:0] hz);
		box_req_t b;
		b.center_x = cx;
		b.center_y = cy;
		b.center_z = cz;
		b.half_x   = hx;
		b.half_y   = hy;
		b.half_z   = hz;
		return b;
	endfunction

	task automatic queue_box(input box_req_t b, input bit drain_first);
		queued_box_t q;
		q.box         = b;
		q.drain_first = drain_first;
		pending_boxes.push_back(q);
	endtask

	function automatic logic [COORD_W-1:0] rand_center(input int mode);
		case (mode)
			0: return $urandom;
			1: return COORD_W'(int'($urandom_range(2 ** 25)) - 2 ** 24);
			2: return COORD_W'(int'($urandom_range(2 ** 9)) - 2 ** 8);
			default: begin
				case ($urandom_range(3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	function automatic logic [HALF_W-1:0] rand_half(input int mode);
		case (mode)
			0: return HALF_W'($urandom);
			1: return HALF_W'($urandom_range(2 ** 22));
			2: return HALF_W'($urandom_range(64));
			default: return $urandom_range(1) ? H_MAX : '0;
		endcase
	endfunction

	function automatic box_req_t rand_box();
		int mode;
		box_req_t b;
		mode = $urandom_range(7);
		if (mode >= 4) begin
			mode = 1 + (mode & 1);
		end
		b = make_box(rand_center(mode), rand_center(mode), rand_center(mode),
			rand_half(mode), rand_half(mode), rand_half(mode));
		if ($urandom_range(9) == 0) begin
			b.half_x = '0;
			b.half_y = '0;
			b.half_z = '0;
		end
		return b;
	endfunction

	task automatic run_directed(input int idle_pct);
		send_idle_pct = idle_pct;
		queue_box(make_box('0, '0, '0, '0, '0, '0), 1'b0);
		queue_box(make_box('0, '0, '0, H_MAX, H_MAX, H_MAX), 1'b0);
		queue_box(make_box(Q_MAX, Q_MAX, Q_MAX, H_MAX, H_MAX, H_MAX), 1'b0);
		queue_box(make_box(Q_MIN, Q_MIN, Q_MIN, H_MAX, H_MAX, H_MAX), 1'b0);
		queue_box(make_box(Q_MAX, Q_MAX, Q_MAX, '0, '0, '0), 1'b0);
		queue_box(make_box(Q_MIN, Q_MIN, Q_MIN, '0, '0, '0), 1'b0);
		queue_box(make_box('1, '1, '1, 31'd1, 31'd1, 31'd1), 1'b0);
		queue_box(make_box(32'd1, '1, Q_ONE, 31'd3, 31'd5, 31'd7), 1'b0);
		queue_box(make_box(Q_MAX, Q_MIN, '0, H_MAX, '0, 31'd1), 1'b0);
		queue_box(make_box(32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
			31'h4000_0000, 31'h4000_0000, 31'h4000_0000), 1'b0);
		queue_box(make_box(32'hC000_0000, 32'hC000_0000, 32'hC000_0000,
			31'h4000_0000, 31'h4000_0000, 31'h4000_0000), 1'b0);
		queue_box(make_box(32'hFFFF_FFF3, 32'h0000_000B, 32'hFFFE_7FFF,
			31'd9, 31'd2, 31'd17), 1'b0);
		wait_idle();
	endtask

	task automatic run_random(input int idle_pct, input int count);
		send_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			queue_box(rand_box(), i == count / 2 || $urandom_range(39) == 0);
		end
		wait_idle();
	endtask

	initial begin
		xform_regs[CFG_ROW_X_XY] = {Q_ONE, 32'h0};
		xform_regs[CFG_ROW_X_ZT] = '0;
		xform_regs[CFG_ROW_Y_XY] = {32'h0, Q_ONE};
		xform_regs[CFG_ROW_Y_ZT] = '0;
		xform_regs[CFG_ROW_Z_XY] = '0;
		xform_regs[CFG_ROW_Z_ZT] = {Q_ONE, 32'h0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed(0);
		run_random(0, 90);
		load_transform(XF_HALF_SCALE);
		run_directed(56);
		run_random(56, 90);
		load_transform(XF_RANDOM);
		run_random(8, 100);
		load_transform(XF_MOST_NEG);
		run_random(0, 90);
		load_transform(XF_MOST_POS);
		run_random(56, 90);
		load_transform(XF_ZERO);
		run_random(8, 70);
		load_transform(XF_SMALL);
		run_random(0, 110);
		load_transform(XF_RANDOM);
		run_random(56, 100);
		load_transform(XF_SMALL);
		run_random(8, 110);
		load_transform(XF_RANDOM);
		run_random(0, 90);

		repeat (10) @(negedge clk);
		if (error_count == 0 && expected_bounds.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
